FILE: src/ctlb_pkg.sv
// ----------------------------------------------------------------------------
// ctlb_pkg: shared definitions for the cursor text line buffer
// Command and status codes, plan codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package ctlb_pkg;

  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;
  localparam int CHAR_W = 8;

  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd5;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] PLAN_FINISH = 2'd0;
  localparam logic [1:0] PLAN_STEP   = 2'd1;
  localparam logic [1:0] PLAN_READ   = 2'd2;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic step_wr;
    logic rd_done;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] plan;
    logic       more;
  } dp_stat_t;

endpackage

FILE: src/ctlb_ram.sv
// ----------------------------------------------------------------------------
// ctlb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ctlb_dp.sv
// ----------------------------------------------------------------------------
// ctlb_dp: datapath of the cursor text line buffer
// Holds the line as a gap buffer in RAM: bytes before the cursor sit at the
// bottom, bytes from the cursor on sit at the top. Also holds the cursor,
// the length, the latched command and the result register.
// ----------------------------------------------------------------------------
module ctlb_dp import ctlb_pkg::*; #(
  parameter int MAX_LEN = 256,
  parameter int POS_W   = 9,
  parameter int AW      = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          st,
  input  logic [CMD_W-1:0]  command,
  input  logic [CHAR_W-1:0] char_in,
  input  logic [POS_W-1:0]  position,
  output logic [ST_W-1:0]   status,
  output logic [POS_W-1:0]  cursor_now,
  output logic [POS_W-1:0]  length_now,
  output logic [CHAR_W-1:0] char_out
);

  localparam logic [POS_W-1:0] MAX_P  = POS_W'(MAX_LEN);
  localparam logic [POS_W-1:0] TOP_P  = POS_W'(MAX_LEN - 1);
  localparam logic [POS_W-1:0] ONE_P  = POS_W'(1);

  logic [CMD_W-1:0]  cmd_q;
  logic [CHAR_W-1:0] ch_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  cursor;
  logic [POS_W-1:0]  cursor_next;
  logic [POS_W-1:0]  len;
  logic [POS_W-1:0]  len_next;
  logic              dir_left;
  logic [ST_W-1:0]   stat_q;
  logic [CHAR_W-1:0] got;

  logic [ST_W-1:0]   exec_stat;
  logic [1:0]        exec_plan;
  logic              exec_left;
  logic              ins_ok;
  logic              del_ok;

  logic [POS_W-1:0]  right_cnt;
  logic [POS_W-1:0]  gap_top;
  logic [POS_W-1:0]  right_src;
  logic [POS_W-1:0]  left_src;
  logic [POS_W-1:0]  rd_addr;
  logic [POS_W-1:0]  step_cursor;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [CHAR_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [CHAR_W-1:0] rdata;

  assign right_cnt   = len - cursor;
  assign gap_top     = TOP_P - right_cnt;
  assign right_src   = MAX_P - right_cnt;
  assign left_src    = cursor - ONE_P;
  assign rd_addr     = (pos_q < cursor) ? pos_q : (pos_q + MAX_P - len);
  assign step_cursor = dir_left ? (cursor - ONE_P) : (cursor + ONE_P);

  assign ins_ok = (cmd_q == CMD_INSERT) && (len != MAX_P);
  assign del_ok = (cmd_q == CMD_DELETE) && (len != '0);

  always_comb begin
    exec_stat = ST_RANGE;
    exec_plan = PLAN_FINISH;
    exec_left = 1'b0;
    case (cmd_q)
      CMD_LEFT: begin
        if (cursor != '0) begin
          exec_stat = ST_DONE;
          exec_plan = PLAN_STEP;
          exec_left = 1'b1;
        end
      end
      CMD_RIGHT: begin
        if (cursor < len) begin
          exec_stat = ST_DONE;
          exec_plan = PLAN_STEP;
        end
      end
      CMD_INSERT: begin
        exec_stat = ins_ok ? ST_DONE : ST_FULL;
      end
      CMD_DELETE: begin
        exec_stat = del_ok ? ST_DONE : ST_EMPTY;
      end
      CMD_MOVE: begin
        if (pos_q <= len) begin
          exec_stat = ST_DONE;
          if (pos_q != cursor) begin
            exec_plan = PLAN_STEP;
            exec_left = pos_q < cursor;
          end
        end
      end
      CMD_READ: begin
        if (pos_q < len) begin
          exec_stat = ST_DONE;
          exec_plan = PLAN_READ;
        end
      end
      default: begin
        exec_stat = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    cursor_next = cursor;
    len_next    = len;
    if (cmd.exec && ins_ok) begin
      len_next = len + ONE_P;
    end
    if (cmd.exec && del_ok) begin
      len_next = len - ONE_P;
      if (cursor == len) begin
        cursor_next = cursor - ONE_P;
      end
    end
    if (cmd.step_wr) begin
      cursor_next = step_cursor;
    end
  end

  assign st.plan = exec_plan;
  assign st.more = (cmd_q == CMD_MOVE) && (step_cursor != pos_q);

  assign we    = (cmd.exec && ins_ok) || cmd.step_wr;
  assign waddr = cmd.exec ? gap_top[AW-1:0] : (dir_left ? gap_top[AW-1:0] : cursor[AW-1:0]);
  assign wdata = cmd.exec ? ch_q : rdata;
  assign raddr = (cmd_q == CMD_READ) ? rd_addr[AW-1:0]
               : (dir_left ? left_src[AW-1:0] : right_src[AW-1:0]);

  ctlb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      len    <= '0;
    end else begin
      cursor <= cursor_next;
      len    <= len_next;
    end
    if (cmd.load_in) begin
      cmd_q <= command;
      ch_q  <= char_in;
      pos_q <= position;
    end
    if (cmd.exec) begin
      stat_q   <= exec_stat;
      dir_left <= exec_left;
      got      <= '0;
    end
    if (cmd.rd_done) begin
      got <= rdata;
    end
    if (cmd.publish) begin
      status     <= cmd.exec ? exec_stat : stat_q;
      cursor_now <= cursor_next;
      length_now <= len_next;
      char_out   <= cmd.rd_done ? rdata : (cmd.exec ? '0 : got);
    end
  end

endmodule

FILE: src/ctlb_ctrl.sv
// ----------------------------------------------------------------------------
// ctlb_ctrl: controller of the cursor text line buffer
// Sequences one command at a time and owns both handshakes.
// ----------------------------------------------------------------------------
module ctlb_ctrl import ctlb_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_STEP_RD = 3'd2;
  localparam logic [2:0] S_STEP_WR = 3'd3;
  localparam logic [2:0] S_RD_WAIT = 3'd4;
  localparam logic [2:0] S_HOLD    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pub_ok;

  assign in_ready = (state == S_IDLE);
  assign pub_ok   = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (st.plan)
          PLAN_STEP: state_next = S_STEP_RD;
          PLAN_READ: state_next = S_RD_WAIT;
          default: begin
            cmd.publish = pub_ok;
            state_next  = pub_ok ? S_IDLE : S_HOLD;
          end
        endcase
      end
      S_STEP_RD: begin
        state_next = S_STEP_WR;
      end
      S_STEP_WR: begin
        cmd.step_wr = 1'b1;
        if (st.more) begin
          state_next = S_STEP_RD;
        end else begin
          cmd.publish = pub_ok;
          state_next  = pub_ok ? S_IDLE : S_HOLD;
        end
      end
      S_RD_WAIT: begin
        cmd.rd_done = 1'b1;
        cmd.publish = pub_ok;
        state_next  = pub_ok ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        cmd.publish = pub_ok;
        state_next  = pub_ok ? S_IDLE : S_HOLD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/cursor_text_line_buffer.sv
// ----------------------------------------------------------------------------
// cursor_text_line_buffer: one-line text buffer with an edit cursor
// Holds up to MAX_LEN bytes and a cursor; commands move the cursor, insert
// and delete bytes, and read a byte back.
// ----------------------------------------------------------------------------
// Usage: a command transaction on the input channel (command, char_in,
// position) gives exactly one result transaction on the output channel
// (status, cursor_now, length_now, char_out), in order.
// The line lives in a RAM as a gap buffer split at the cursor. Insert,
// delete and refused commands finish directly, a read waits for the RAM
// read data, and left, right and move step the cursor one position at a
// time, each step moving one byte across the gap through the single RAM
// read port and then the write port.
// One command is in progress at a time; the next transaction is taken as
// soon as the previous result sits in the output register, even while that
// result still waits for the receiver. While the receiver stalls a finished
// result, the block holds the next one until the output register frees.
// Reset empties the line and puts the cursor at 0; the RAM is not cleared,
// as no byte is read before it has been written.
// ----------------------------------------------------------------------------
module cursor_text_line_buffer import ctlb_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [CMD_W-1:0]                 command,
  input  logic [CHAR_W-1:0]                char_in,
  input  logic [$clog2(MAX_LEN+1)-1:0]     position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ST_W-1:0]                  status,
  output logic [$clog2(MAX_LEN+1)-1:0]     cursor_now,
  output logic [$clog2(MAX_LEN+1)-1:0]     length_now,
  output logic [CHAR_W-1:0]                char_out
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int AW    = $clog2(MAX_LEN);

  dp_cmd_t  cmd;
  dp_stat_t st;

  ctlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ctlb_dp #(
    .MAX_LEN (MAX_LEN),
    .POS_W   (POS_W),
    .AW      (AW)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .command    (command),
    .char_in    (char_in),
    .position   (position),
    .status     (status),
    .cursor_now (cursor_now),
    .length_now (length_now),
    .char_out   (char_out)
  );

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cursor_now <= length_now))
    else $error("cursor beyond line length");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length_now <= POS_W'(MAX_LEN)))
    else $error("line length beyond capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new transaction taken while a command is in progress");

endmodule
